// ===== design/abi_pkg.sv =====
`timescale 1ns / 1ps
// Types, constants and helper functions shared by the integrator modules.
package abi_pkg;

  // Input item as it arrives on the push side.
  typedef struct packed {
    logic [3:0]          component;
    logic signed [31:0]  state_value;
    logic signed [31:0]  derivative_value;
    logic                last_component;
  } in_item_t;

  // Result item as it leaves on the pop side.
  typedef struct packed {
    logic [3:0]          out_component;
    logic signed [31:0]  new_value;
    logic [2:0]          order_used;
    logic                saturated;
  } out_item_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic [3:0]          component;
    logic [3:0]          idx;
    logic [1:0]          slot;
    logic [2:0]          used;
    logic signed [31:0]  state_value;
    logic signed [31:0]  derivative_value;
  } desc_t;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] REG_METHOD_ORDER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 1'd1;
  localparam logic [2:0]  METHOD_ORDER_RESET = 3'd1;
  localparam logic [16:0] STEP_SIZE_RESET    = 17'd655;

  // Queue depths (powers of two).
  localparam int DESC_DEPTH = 4;
  localparam int OUT_DEPTH  = 16;

  // Coefficient numerators over 24, one row per order.
  localparam logic signed [7:0] COEF_NUM [4][4] = '{
    '{8'sd24,  8'sd0,   8'sd0,  8'sd0},
    '{8'sd36, -8'sd12,  8'sd0,  8'sd0},
    '{8'sd46, -8'sd32,  8'sd10, 8'sd0},
    '{8'sd55, -8'sd59,  8'sd37, -8'sd9}
  };

  // Datapath widths.
  localparam int SUM_W  = 40;   // sum of four coefficient products
  localparam int PROD_W = 58;   // sum times step size
  localparam int T_W    = PROD_W - 19;

  // Divide by 24 * 65536 = 3 * 2^19: add half, shift by 19, divide by 3.
  localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(786432);
  localparam logic [T_W-1:0]    SAT_LIMIT  = T_W'(64'h3_0000_0000);
  localparam logic [19:0]       DIV3_MUL   = 20'd699051;  // ceil(2^21 / 3)

  // Exact floor(n / 3) for n below 2^19.
  function automatic logic [17:0] div3(input logic [18:0] n);
    logic [38:0] p;
    p = 39'(n) * 39'(DIV3_MUL);
    return p[38:21];
  endfunction

endpackage

// ===== design/abi_queue.sv =====
`timescale 1ns / 1ps
// Small synchronous first-in first-out queue with full and empty flags.
module abi_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/abi_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts items, tracks step head and history fill, classifies items.
module abi_front #(
  parameter int VECTOR_SIZE = 16,
  parameter int MAX_ORDER   = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [2:0]        method_order,
  input  logic              push,
  input  abi_pkg::in_item_t item,
  input  logic              desc_full,
  output logic              desc_push,
  output abi_pkg::desc_t    desc
);

  logic [3:0] idx_tbl [16];
  logic [1:0] head;
  logic [2:0] fill;
  logic [2:0] ord;
  logic [2:0] used;
  logic       accept;

  // Component to history row, worked out at elaboration.
  for (genvar g = 0; g < 16; g++) begin : g_idx
    assign idx_tbl[g] = 4'(g % VECTOR_SIZE);
  end

  always_comb begin
    accept = push && !desc_full;
    ord = (method_order inside {[3'd1:3'd4]}) ? method_order : 3'd1;
    if (ord > 3'(MAX_ORDER)) begin
      ord = 3'(MAX_ORDER);
    end
    used = fill + 3'd1;
    if (used > ord) begin
      used = ord;
    end
    desc.component        = item.component;
    desc.idx              = idx_tbl[item.component];
    desc.slot             = head;
    desc.used             = used;
    desc.state_value      = item.state_value;
    desc.derivative_value = item.derivative_value;
  end

  assign desc_push = accept;

  // Advance the ring head and the fill count at the end of each step.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else if (accept && item.last_component) begin
      head <= (head == 2'(MAX_ORDER - 1)) ? 2'd0 : head + 2'd1;
      if (fill < 3'(MAX_ORDER)) begin
        fill <= fill + 3'd1;
      end
    end
  end

endmodule

// ===== design/abi_back.sv =====
`timescale 1ns / 1ps
// Back end: history memory and the multiply-accumulate, rounding, saturation pipeline.
module abi_back #(
  parameter int VECTOR_SIZE = 16,
  parameter int MAX_ORDER   = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [16:0]        step_size,
  input  logic               desc_empty,
  input  abi_pkg::desc_t     desc,
  output logic               desc_pop,
  input  logic               res_taken,
  output logic               res_push,
  output abi_pkg::out_item_t res
);

  localparam int ROWS   = (VECTOR_SIZE < 16) ? VECTOR_SIZE : 16;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LANE_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CRED_W = $clog2(abi_pkg::OUT_DEPTH + 1);
  localparam int SUM_W  = abi_pkg::SUM_W;
  localparam int PROD_W = abi_pkg::PROD_W;
  localparam int T_W    = abi_pkg::T_W;

  typedef struct packed {
    logic [3:0]         component;
    logic [2:0]         used;
    logic signed [31:0] state_value;
  } meta_t;

  // History: one row per component, one lane per ring slot.
  logic [MAX_ORDER-1:0][31:0] hist [ROWS];

  logic [CRED_W-1:0] credits;
  logic              issue;

  // Stage registers.
  logic                              v1, v2, v3, v4, v5, v6, v7, v8;
  meta_t                             m1, m2, m3, m4, m5, m6, m7, m8;
  logic [1:0]                        s1_slot;
  logic signed [31:0]                s1_f;
  logic [MAX_ORDER-1:0][31:0]        s1_row;
  logic signed [SUM_W-1:0]           s2_prod [MAX_ORDER];
  logic signed [SUM_W-1:0]           s3_sum;
  logic signed [PROD_W-1:0]          s4_prod;
  logic [PROD_W-1:0]                 s5_mag;
  logic                              s5_neg, s6_neg, s7_neg, s8_neg;
  logic [T_W-1:0]                    s6_t;
  logic                              s6_big, s7_big, s8_big;
  logic [16:0]                       s7_a;
  logic [16:0]                       s7_b;
  logic [15:0]                       s7_qa;
  logic [32:0]                       s8_q;

  // Combinational values.
  logic signed [SUM_W-1:0]  prod_next [MAX_ORDER];
  logic signed [SUM_W-1:0]  sum_next;
  logic [PROD_W-1:0]        mag_biased;
  logic [17:0]              qa_next;
  logic [16:0]              ra_full;
  logic [17:0]              qb_next;
  logic [34:0]              x_ext;
  logic [34:0]              q_ext;
  logic [34:0]              r;

  // Reserve a result-queue entry before an item enters the pipeline, so the
  // pipeline never has to stall.
  assign issue    = !desc_empty && (credits < CRED_W'(abi_pkg::OUT_DEPTH));
  assign desc_pop = issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else if (issue && !res_taken) begin
      credits <= credits + 1'b1;
    end else if (res_taken && !issue) begin
      credits <= credits - 1'b1;
    end
  end

  // History write of the current slot and read of the whole row.
  always_ff @(posedge clk) begin
    if (issue) begin
      hist[desc.idx[ROW_W-1:0]][desc.slot[LANE_W-1:0]] <= desc.derivative_value;
      s1_row <= hist[desc.idx[ROW_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
    end
  end

  // Coefficient products; the current slot comes from the item itself.
  // Lanes past the active row are forced to zero so that an entry never
  // written cannot reach the sum.
  always_comb begin
    logic [2:0] s;
    logic [2:0] ls;
    logic [31:0] f;
    for (int i = 0; i < MAX_ORDER; i++) begin
      s = {1'b0, s1_slot};
      if (s >= 3'(i)) begin
        ls = s - 3'(i);
      end else begin
        ls = s + 3'(MAX_ORDER) - 3'(i);
      end
      if (3'(i) < m1.used) begin
        f = (i == 0) ? s1_f : s1_row[ls[LANE_W-1:0]];
      end else begin
        f = '0;
      end
      prod_next[i] = $signed(f) *
                     abi_pkg::COEF_NUM[m1.used[1:0] - 2'd1][i];
    end
  end

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < MAX_ORDER; i++) begin
      sum_next = sum_next + s2_prod[i];
    end
  end

  always_comb begin
    mag_biased = s5_mag + abi_pkg::ROUND_BIAS;
    qa_next    = abi_pkg::div3({2'b00, s6_t[33:17]});
    ra_full    = s7_a - (17'(s7_qa) + {s7_qa[15:0], 1'b0});
    qb_next    = abi_pkg::div3({ra_full[1:0], s7_b});
    x_ext      = {{3{m8.state_value[31]}}, m8.state_value};
    q_ext      = {2'b00, s8_q};
    r          = s8_neg ? (x_ext - q_ext) : (x_ext + q_ext);
  end

  always_ff @(posedge clk) begin
    // Stage 1: row read, item payload.
    if (issue) begin
      m1.component   <= desc.component;
      m1.used        <= desc.used;
      m1.state_value <= desc.state_value;
      s1_slot        <= desc.slot;
      s1_f           <= desc.derivative_value;
    end
    // Stage 2: products.
    m2 <= m1;
    for (int i = 0; i < MAX_ORDER; i++) begin
      s2_prod[i] <= prod_next[i];
    end
    // Stage 3: sum.
    m3     <= m2;
    s3_sum <= sum_next;
    // Stage 4: times step size.
    m4      <= m3;
    s4_prod <= s3_sum * $signed({1'b0, step_size});
    // Stage 5: magnitude and sign.
    m5     <= m4;
    s5_neg <= s4_prod[PROD_W-1];
    s5_mag <= s4_prod[PROD_W-1] ? PROD_W'(-s4_prod) : PROD_W'(s4_prod);
    // Stage 6: round and drop the power-of-two part of the divisor.
    m6     <= m5;
    s6_neg <= s5_neg;
    s6_t   <= mag_biased[PROD_W-1:19];
    s6_big <= (mag_biased[PROD_W-1:19] >= abi_pkg::SAT_LIMIT);
    // Stage 7: divide the high half by three.
    m7     <= m6;
    s7_neg <= s6_neg;
    s7_big <= s6_big;
    s7_a   <= s6_t[33:17];
    s7_b   <= s6_t[16:0];
    s7_qa  <= qa_next[15:0];
    // Stage 8: divide remainder plus low half by three.
    m8     <= m7;
    s8_neg <= s7_neg;
    s8_big <= s7_big;
    s8_q   <= {s7_qa, qb_next[16:0]};
  end

  // Final add and saturation.
  always_comb begin
    res.out_component = m8.component;
    res.order_used    = m8.used;
    if (s8_big) begin
      res.saturated = 1'b1;
      res.new_value = s8_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (!r[34] && (r[33:31] != 3'b000)) begin
      res.saturated = 1'b1;
      res.new_value = 32'sh7FFF_FFFF;
    end else if (r[34] && (r[33:31] != 3'b111)) begin
      res.saturated = 1'b1;
      res.new_value = 32'sh8000_0000;
    end else begin
      res.saturated = 1'b0;
      res.new_value = $signed(r[31:0]);
    end
  end

  assign res_push = v8;

endmodule

// ===== design/adams_bashforth_integrator.sv =====
`timescale 1ns / 1ps
// Top level of the Adams-Bashforth order 1 to 4 fixed-point integrator.
//
// Usage:
//   Input side is a queue: drive item and raise push; a transfer happens on a
//   rising edge with push high and full low. Result side is a queue too: while
//   empty is low, result holds the oldest result; pop takes it on a rising edge
//   with pop high and empty low. Configuration writes use cfg_valid/cfg_ready
//   (cfg_ready is always high): index 0 is method_order, index 1 is step_size.
//   Write configuration only while no item is in flight.
// Timing:
//   One item per cycle sustained while results are popped. A result passes
//   through the classifier queue and the back-end pipeline stages (row read,
//   products, sum, step-size multiply, magnitude, rounding shift, and two
//   divide-by-three stages) before it shows on the result side.
// Stalls:
//   The back end reserves a slot in the 16-entry result queue before an item
//   enters its pipeline. When pop stays low, the pipeline drains into that
//   queue, the 4-entry classifier queue fills, and full rises; nothing drops.
// Reset:
//   Clears the queues, the ring head and the history fill count, and loads
//   method_order = 1 and step_size = 655. Derivative history is not cleared;
//   an entry must be read only after a step wrote it; the block does not check.
module adams_bashforth_integrator #(
  parameter int VECTOR_SIZE = 16,
  parameter int MAX_ORDER   = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  abi_pkg::in_item_t               item,
  output logic                            empty,
  input  logic                            pop,
  output abi_pkg::out_item_t              result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [abi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [abi_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [2:0]          method_order;
  logic [16:0]         step_size;

  logic                desc_push;
  logic                desc_full;
  logic                desc_empty;
  logic                desc_pop;
  abi_pkg::desc_t      desc_in;
  abi_pkg::desc_t      desc_out;

  logic                res_push;
  logic                res_taken;
  abi_pkg::out_item_t  res_item;

  assign cfg_ready = 1'b1;
  assign full      = desc_full;
  assign res_taken = pop && !empty;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      method_order <= abi_pkg::METHOD_ORDER_RESET;
      step_size    <= abi_pkg::STEP_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        abi_pkg::REG_METHOD_ORDER: method_order <= cfg_data[2:0];
        abi_pkg::REG_STEP_SIZE:    step_size    <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // Front: classify and track the step ring.
  abi_front #(
    .VECTOR_SIZE (VECTOR_SIZE),
    .MAX_ORDER   (MAX_ORDER)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .method_order (method_order),
    .push         (push),
    .item         (item),
    .desc_full    (desc_full),
    .desc_push    (desc_push),
    .desc         (desc_in)
  );

  // Short queue between front and back.
  abi_queue #(
    .WIDTH ($bits(abi_pkg::desc_t)),
    .DEPTH (abi_pkg::DESC_DEPTH)
  ) u_desc_q (
    .clk   (clk),
    .rst   (rst),
    .push  (desc_push),
    .wdata (desc_in),
    .full  (desc_full),
    .pop   (desc_pop),
    .rdata (desc_out),
    .empty (desc_empty)
  );

  // Back: history and arithmetic pipeline.
  abi_back #(
    .VECTOR_SIZE (VECTOR_SIZE),
    .MAX_ORDER   (MAX_ORDER)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .step_size  (step_size),
    .desc_empty (desc_empty),
    .desc       (desc_out),
    .desc_pop   (desc_pop),
    .res_taken  (res_taken),
    .res_push   (res_push),
    .res        (res_item)
  );

  // Result queue; never overflows thanks to the back end's reservations.
  abi_queue #(
    .WIDTH ($bits(abi_pkg::out_item_t)),
    .DEPTH (abi_pkg::OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_item),
    .full  (),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

// ===== tb/adams_bashforth_integrator_checker.sv =====
`timescale 1ns / 1ps
// Watches the integrator's channels, predicts each result and compares field by field.
module adams_bashforth_integrator_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            full,
  input  abi_pkg::in_item_t               item,
  input  logic                            empty,
  input  logic                            pop,
  input  abi_pkg::out_item_t              result,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [abi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [abi_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              errors,
  output int                              outstanding
);

  // 24 * 65536: the common denominator of the coefficient rows times one in Q16.16
  localparam longint unsigned STEP_DEN  = 64'd1572864;
  localparam longint unsigned STEP_HALF = 64'd786432;
  localparam longint          WORD_MAX  = 64'sd2147483647;
  localparam longint          WORD_MIN  = -64'sd2147483648;

  int row_weights [4][4] = '{
    '{24, 0, 0, 0},
    '{36, -12, 0, 0},
    '{46, -32, 10, 0},
    '{55, -59, 37, -9}
  };

  logic signed [31:0]  slope_log [4][16];
  int unsigned         ring_fill;
  int unsigned         ring_head;
  logic [2:0]          order_reg;
  logic [16:0]         dt_reg;
  abi_pkg::out_item_t  awaited_updates [$];
  abi_pkg::out_item_t  want;
  int                  fail_tally = 0;

  assign errors = fail_tally;

  // Log the new slope, then form x + dt * sum(b[i] * f[n-i]) with rounding and clipping.
  function automatic abi_pkg::out_item_t integrate_component(input abi_pkg::in_item_t it);
    abi_pkg::out_item_t r;
    int unsigned     ordc;
    int unsigned     used;
    int unsigned     i;
    longint          acc;
    longint          total;
    longint unsigned mag;
    longint unsigned q;
    logic            neg;
    ordc = (order_reg >= 3'd1 && order_reg <= 3'd4) ? int'(order_reg) : 1;
    used = (ring_fill + 1 < ordc) ? ring_fill + 1 : ordc;
    slope_log[ring_head][it.component] = it.derivative_value;
    acc = 0;
    for (i = 0; i < used; i++)
      acc += longint'(row_weights[used-1][i]) *
             longint'(slope_log[(ring_head + 4 - i) % 4][it.component]);
    acc = acc * longint'(dt_reg);
    neg = (acc < 0);
    mag = neg ? longint'(-acc) : acc;
    q = (mag + STEP_HALF) / STEP_DEN;
    total = longint'(it.state_value) + (neg ? -longint'(q) : longint'(q));
    r.saturated = 1'b0;
    if (total > WORD_MAX) begin
      total = WORD_MAX;
      r.saturated = 1'b1;
    end else if (total < WORD_MIN) begin
      total = WORD_MIN;
      r.saturated = 1'b1;
    end
    r.out_component = it.component;
    r.new_value = total[31:0];
    r.order_used = used[2:0];
    if (it.last_component) begin
      ring_head = (ring_head + 1) % 4;
      if (ring_fill < 4) ring_fill++;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 4; s++)
        for (int c = 0; c < 16; c++) slope_log[s][c] = '0;
      ring_fill = 0;
      ring_head = 0;
      order_reg = abi_pkg::METHOD_ORDER_RESET;
      dt_reg = abi_pkg::STEP_SIZE_RESET;
      awaited_updates.delete();
    end else begin
      // Results leave later than their item enters, so compare before logging new items.
      if (pop && !empty) begin
        if (awaited_updates.size() == 0) begin
          $error("unexpected result for component %0d", result.out_component);
          fail_tally++;
        end else begin
          want = awaited_updates.pop_front();
          if (result.out_component !== want.out_component) begin
            $error("out_component: expected %0d, got %0d", want.out_component,
                   result.out_component);
            fail_tally++;
          end
          if (result.new_value !== want.new_value) begin
            $error("new_value: expected %0d, got %0d", want.new_value, result.new_value);
            fail_tally++;
          end
          if (result.order_used !== want.order_used) begin
            $error("order_used: expected %0d, got %0d", want.order_used, result.order_used);
            fail_tally++;
          end
          if (result.saturated !== want.saturated) begin
            $error("saturated: expected %0d, got %0d", want.saturated, result.saturated);
            fail_tally++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          abi_pkg::REG_METHOD_ORDER: order_reg = cfg_data[2:0];
          abi_pkg::REG_STEP_SIZE:    dt_reg = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) awaited_updates.push_back(integrate_component(item));
    end
    outstanding <= awaited_updates.size();
  end

endmodule

// ===== tb/adams_bashforth_integrator_test.sv =====
`timescale 1ns / 1ps
// Top of the integrator testbench: clock, reset, stimulus, flow control and verdict.
module adams_bashforth_integrator_test;

  // Cycles with no transfer of any kind before the run is declared hung.
  localparam int IDLE_LIMIT   = 2000;
  // Extra cycles to wait at the end once every result has been checked.
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 128;

  logic                           clk;
  logic                           rst;
  logic                           push;
  logic                           full;
  abi_pkg::in_item_t              item;
  logic                           empty;
  logic                           pop;
  abi_pkg::out_item_t             result;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [abi_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [abi_pkg::CFG_DATA_W-1:0] cfg_data;

  int errors;
  int outstanding;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  // Settings per random phase; a negative step size means pick one at random.
  int phase_order [PHASES] = '{1, 2, 3, 4, 0, 5, 6, 7, 4, 3, 2, 4};
  int phase_step  [PHASES] = '{655, 0, 65536, 131071, -1, -1, 1, 131071, -1, 65536, -1, 32768};

  // Stimulus-side view of the history ring, kept only so that no item ever reads
  // a history entry that has not been written since reset.
  logic [15:0] logged [4] = '{16'h0, 16'h0, 16'h0, 16'h0};
  int unsigned ring_head_m = 0;
  int unsigned ring_fill_m = 0;
  logic [2:0]  order_m = abi_pkg::METHOD_ORDER_RESET;

  adams_bashforth_integrator dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  adams_bashforth_integrator_checker scoreboard (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .item        (item),
    .empty       (empty),
    .pop         (pop),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: take the head of the queue whenever the receiver is not stalling.
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Hang detector: restart the count on every transfer of any channel.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Mix of extremes, full-range words and small values so that not every
  // result clips.
  function automatic logic [31:0] sample_word();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2: return $urandom;
      default: return 32'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
    endcase
  endfunction

  // Offer one item after a random sender gap, hold it until the transfer,
  // then advance the stimulus-side ring.
  task automatic offer(input logic [3:0] comp, input logic [31:0] x, input logic [31:0] f,
                       input logic last);
    abi_pkg::in_item_t it;
    it.component = comp;
    it.state_value = x;
    it.derivative_value = f;
    it.last_component = last;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    item <= it;
    push <= 1'b1;
    // Sample full as the edge sees it: the transfer is the edge with full low.
    @(posedge clk iff !full);
    logged[ring_head_m][comp] = 1'b1;
    if (last) begin
      ring_head_m = (ring_head_m + 1) % 4;
      if (ring_fill_m < 4) ring_fill_m++;
    end
  endtask

  // Drain the block, then write both registers. The order goes out with
  // random upper data bits, which the register must ignore.
  task automatic retune(input logic [2:0] order, input logic [16:0] dt);
    push <= 1'b0;
    // Let the checker log the last transfer before trusting its count.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= abi_pkg::REG_METHOD_ORDER;
    cfg_data <= {14'($urandom), order};
    @(posedge clk iff cfg_ready);
    cfg_index <= abi_pkg::REG_STEP_SIZE;
    cfg_data <= dt;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
    order_m = order;
  endtask

  initial begin
    int unsigned ordc;
    int unsigned used;
    int unsigned k;
    logic [3:0]  comp;
    logic [3:0]  prev;
    logic        ok;
    logic        first;
    logic [16:0] dt;

    rst <= 1'b1;
    push <= 1'b0;
    item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    send_idle_pct = 24;
    recv_idle_pct = 80;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Start-up rows at order 4 with dt = 1.0: components 0 and 15 appear in
    // every step, so the lower rows are used while the history fills up.
    retune(3'd4, 17'd65536);
    // First step: clip high and clip low.
    offer(4'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    offer(4'd15, 32'h8000_0000, 32'h8000_0000, 1'b1);
    // Second step: component 15 twice, the second overwrites its slope.
    offer(4'd0, 32'h0000_0000, 32'h0001_0000, 1'b0);
    offer(4'd15, 32'h1234_5678, 32'hFFFF_0000, 1'b0);
    offer(4'd15, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
    offer(4'd0, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    offer(4'd15, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1);
    offer(4'd0, 32'h0000_0000, 32'h0000_0000, 1'b0);
    offer(4'd15, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1);
    // History full: the complete fourth-order row.
    offer(4'd0, 32'h0001_0000, 32'h8000_0000, 1'b0);
    offer(4'd15, 32'hFFFF_0000, 32'h7FFF_FFFF, 1'b1);

    // Rounding ties at order 1 with dt = 0.5: +-0.5 and 1.5 round away from zero.
    retune(3'd1, 17'd32768);
    offer(4'd3, 32'h0000_0000, 32'h0000_0001, 1'b0);
    offer(4'd3, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    offer(4'd3, 32'h0000_000A, 32'h0000_0003, 1'b1);

    // Out-of-range order acts as 1; the largest step size drives clipping.
    retune(3'd7, 17'h1FFFF);
    offer(4'd5, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    offer(4'd5, 32'h8000_0000, 32'h8000_0000, 1'b1);

    prev = 4'd0;
    for (int p = 0; p < PHASES; p++) begin
      // Idle pattern: sender light / receiver heavy, then swapped, then none.
      if (p < 4) begin
        send_idle_pct = 24;
        recv_idle_pct = 80;
      end else if (p < 8) begin
        send_idle_pct = 80;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      dt = (phase_step[p] < 0) ? 17'($urandom_range(0, 131071)) : 17'(phase_step[p]);
      retune(3'(phase_order[p]), dt);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        ordc = (order_m >= 3'd1 && order_m <= 3'd4) ? int'(order_m) : 1;
        used = (ring_fill_m + 1 < ordc) ? ring_fill_m + 1 : ordc;
        // Pick a component whose older slopes in the active row all exist;
        // now and then repeat the previous one.
        ok = 1'b0;
        first = 1'b1;
        while (!ok) begin
          comp = (first && $urandom_range(0, 7) == 0) ? prev : 4'($urandom_range(0, 15));
          first = 1'b0;
          ok = 1'b1;
          for (k = 1; k < used; k++)
            if (!logged[(ring_head_m + 4 - k) % 4][comp]) ok = 1'b0;
        end
        offer(comp, sample_word(), sample_word(), $urandom_range(0, 5) == 0);
        prev = comp;
      end
    end

    // Drain: every item has one result, then allow the pipeline to settle.
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
